// ----- rtl/core/utf8_multibyte_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// utf8 multibyte decoder assertion macros
// Concurrent checks on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_MULTIBYTE_DECODER_DEFINES_SVH
`define UTF8_MULTIBYTE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define UMD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("utf8 decoder check failed");
// condition must never be seen out of reset
`define UMD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("utf8 decoder forbidden condition seen");
`else
`define UMD_ASSERT(lbl, prop)
`define UMD_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- rtl/core/utf8md_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8md_pkg
// Types and constants shared by the utf8 multibyte decoder modules.
// ----------------------------------------------------------------------------
package utf8md_pkg;

  // queue depth between the parts
  localparam int unsigned QueueDepthDef = 4;

  // configuration register indices
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_CESU_MODE      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOOSE_MODE     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALLOW_NUL      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ALLOW_OVERLONG = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ALLOW_SUPER    = 3'd4;
  localparam int unsigned CfgDataW = 1;

  // input action codes
  localparam logic ACT_DECODE = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  // code point constants
  localparam int unsigned CpW = 31;
  localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
  localparam logic [CpW-1:0] SUPP_BASE    = 31'h0001_0000;

  typedef enum logic [1:0] {
    KIND_NEED   = 2'd0,
    KIND_HELD   = 2'd1,
    KIND_EMIT   = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  // class of one raw byte
  typedef enum logic [2:0] {
    BC_ASCII = 3'd0,
    BC_CONT  = 3'd1,
    BC_LEAD2 = 3'd2,
    BC_LEAD3 = 3'd3,
    BC_LEAD4 = 3'd4,
    BC_LEAD5 = 3'd5,
    BC_LEAD6 = 3'd6,
    BC_BAD   = 3'd7
  } byte_cls_e;

  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    kind_e          kind;
    logic [CpW-1:0] code_point;
    logic           last;
  } out_item_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic      flush;
    byte_cls_e cls;
    logic [7:0] data;
  } cls_item_t;

  // configuration register group
  typedef struct packed {
    logic cesu_mode;
    logic loose_mode;
    logic allow_nul;
    logic allow_overlong;
    logic allow_super;
  } cfg_t;

endpackage

// ----- rtl/core/utf8md_fifo.sv -----
// ----------------------------------------------------------------------------
// utf8md_fifo
// Small synchronous queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`include "utf8_multibyte_decoder_defines.svh"

module utf8md_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned Depth  = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `UMD_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth))
  `UMD_ASSERT(a_cnt_push, do_push && !do_pop |=> cnt_q == CntW'($past(cnt_q) + 1'b1))

endmodule

// ----- rtl/core/utf8md_front.sv -----
// ----------------------------------------------------------------------------
// utf8md_front
// Input side: sorts each incoming byte into its utf-8 role.
// ----------------------------------------------------------------------------
module utf8md_front (
  input  logic                  push_i,
  input  utf8md_pkg::in_item_t  item_i,
  output logic                  q_push_o,
  output utf8md_pkg::cls_item_t q_data_o
);
  import utf8md_pkg::*;

  byte_cls_e cls;
  logic [7:0] b;

  assign b = item_i.in_byte;

  // lead byte length from the count of leading ones
  always_comb begin
    priority if (b[7] == 1'b0) begin
      cls = BC_ASCII;
    end else if (b[7:6] == 2'b10) begin
      cls = BC_CONT;
    end else if (b[7:5] == 3'b110) begin
      cls = BC_LEAD2;
    end else if (b[7:4] == 4'b1110) begin
      cls = BC_LEAD3;
    end else if (b[7:3] == 5'b11110) begin
      cls = BC_LEAD4;
    end else if (b[7:2] == 6'b111110) begin
      cls = BC_LEAD5;
    end else if (b[7:1] == 7'b1111110) begin
      cls = BC_LEAD6;
    end else begin
      cls = BC_BAD;
    end
  end

  assign q_push_o       = push_i;
  assign q_data_o.flush = (item_i.action == ACT_FLUSH);
  assign q_data_o.cls   = cls;
  assign q_data_o.data  = b;

endmodule

// ----- rtl/core/utf8md_back.sv -----
// ----------------------------------------------------------------------------
// utf8md_back
// Sequence state, surrogate pairing and result generation, one beat at a time.
// ----------------------------------------------------------------------------
`include "utf8_multibyte_decoder_defines.svh"

module utf8md_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  utf8md_pkg::cfg_t       cfg_i,
  input  logic                   item_valid_i,
  input  utf8md_pkg::cls_item_t  item_i,
  output logic                   item_pop_o,
  input  logic                   res_full_i,
  output logic                   res_push_o,
  output utf8md_pkg::out_item_t  res_data_o
);
  import utf8md_pkg::*;

  // sequence state
  logic [2:0]     rem_q, rem_d;
  logic           first_q, first_d;
  logic [CpW-1:0] acc_q, acc_d;
  logic [15:0]    held_q, held_d;
  // second result of a beat waiting for a slot
  logic           pend_valid_q, pend_valid_d;
  out_item_t      pend_q;

  logic [1:0]     n_res;
  kind_e          k0, k1;
  logic [CpW-1:0] c0, c1;
  logic [CpW-1:0] acc_new;
  logic [CpW-1:0] u;
  logic           rej;
  logic           overlong_hit;
  logic           is_high, is_low, held_any;
  logic           step;
  out_item_t      r0, r1;

  assign acc_new  = {acc_q[CpW-7:0], item_i.data[5:0]};
  assign u        = acc_new;
  assign held_any = (held_q != '0);
  assign is_high  = (u >= CpW'(HIGH_SURR_FIRST)) && (u <= CpW'(HIGH_SURR_LAST));
  assign is_low   = (u >= CpW'(LOW_SURR_FIRST)) && (u <= CpW'(LOW_SURR_LAST));

  // overlong test once the deciding bits are in
  always_comb begin
    unique case (rem_q)
      3'd2:    overlong_hit = (acc_new[CpW-1:5] == '0);
      3'd3:    overlong_hit = (acc_new[CpW-1:4] == '0);
      3'd4:    overlong_hit = (acc_new[CpW-1:3] == '0);
      3'd5:    overlong_hit = (acc_new[CpW-1:2] == '0);
      default: overlong_hit = 1'b0;
    endcase
  end

  // decode one beat
  always_comb begin
    rem_d   = rem_q;
    first_d = first_q;
    acc_d   = acc_q;
    held_d  = held_q;
    n_res   = 2'd0;
    k0      = KIND_NEED;
    c0      = '0;
    k1      = KIND_NEED;
    c1      = '0;
    rej     = 1'b0;
    if (item_i.flush) begin
      if (held_any && cfg_i.loose_mode) begin
        n_res  = 2'd1;
        k0     = KIND_EMIT;
        c0     = CpW'(held_q);
        held_d = '0;
      end
    end else if (rem_q == '0) begin
      n_res = 2'd1;
      unique case (item_i.cls)
        BC_LEAD2: begin
          if (!cfg_i.allow_overlong && item_i.data[4:1] == '0) begin
            rej = 1'b1;
          end else begin
            acc_d   = CpW'(item_i.data[4:0]);
            rem_d   = 3'd1;
            first_d = 1'b0;
          end
        end
        BC_LEAD3: begin
          acc_d   = CpW'(item_i.data[3:0]);
          rem_d   = 3'd2;
          first_d = 1'b1;
        end
        BC_LEAD4: begin
          acc_d   = CpW'(item_i.data[2:0]);
          rem_d   = 3'd3;
          first_d = 1'b1;
        end
        BC_LEAD5: begin
          if (!cfg_i.allow_super) begin
            rej = 1'b1;
          end else begin
            acc_d   = CpW'(item_i.data[1:0]);
            rem_d   = 3'd4;
            first_d = 1'b1;
          end
        end
        BC_LEAD6: begin
          if (!cfg_i.allow_super) begin
            rej = 1'b1;
          end else begin
            acc_d   = CpW'(item_i.data[0]);
            rem_d   = 3'd5;
            first_d = 1'b1;
          end
        end
        default: rej = 1'b1;
      endcase
    end else begin
      n_res = 2'd1;
      if (item_i.cls != BC_CONT || rem_q > 3'd5) begin
        rej = 1'b1;
      end else if (first_q && rem_q >= 3'd2 && !cfg_i.allow_overlong && overlong_hit) begin
        rej = 1'b1;
      end else if (rem_q != 3'd1) begin
        rem_d   = 3'(rem_q - 3'd1);
        first_d = 1'b0;
        acc_d   = acc_new;
      end else begin
        // last byte of the form: check the value
        rem_d   = '0;
        first_d = 1'b0;
        acc_d   = '0;
        if (is_high) begin
          if (cfg_i.cesu_mode) begin
            if (held_any && !cfg_i.loose_mode) begin
              rej = 1'b1;
            end else if (held_any) begin
              n_res  = 2'd2;
              k0     = KIND_EMIT;
              c0     = CpW'(held_q);
              k1     = KIND_HELD;
              held_d = u[15:0];
            end else begin
              k0     = KIND_HELD;
              held_d = u[15:0];
            end
          end else if (cfg_i.loose_mode) begin
            k0 = KIND_EMIT;
            c0 = u;
          end else begin
            rej = 1'b1;
          end
        end else if (is_low) begin
          if (cfg_i.cesu_mode && held_any) begin
            k0     = KIND_EMIT;
            c0     = SUPP_BASE | CpW'({held_q[9:0], u[9:0]});
            held_d = '0;
          end else if (cfg_i.loose_mode) begin
            k0 = KIND_EMIT;
            c0 = u;
          end else begin
            rej = 1'b1;
          end
        end else if (held_any && !cfg_i.loose_mode) begin
          rej = 1'b1;
        end else if (held_any) begin
          // flush the held surrogate ahead of the new value
          n_res  = 2'd2;
          k0     = KIND_EMIT;
          c0     = CpW'(held_q);
          held_d = '0;
          if (u == '0 && !cfg_i.allow_nul) begin
            k1 = KIND_REJECT;
          end else begin
            k1 = KIND_EMIT;
            c1 = u;
          end
        end else if (u == '0 && !cfg_i.allow_nul) begin
          rej = 1'b1;
        end else begin
          k0 = KIND_EMIT;
          c0 = u;
        end
      end
    end
    // a reject clears everything
    if (rej) begin
      n_res   = 2'd1;
      k0      = KIND_REJECT;
      c0      = '0;
      rem_d   = '0;
      first_d = 1'b0;
      acc_d   = '0;
      held_d  = '0;
    end
  end

  assign r0.kind       = k0;
  assign r0.code_point = c0;
  assign r0.last       = (n_res == 2'd1);
  assign r1.kind       = k1;
  assign r1.code_point = c1;
  assign r1.last       = 1'b1;

  // handshake with both queues
  always_comb begin
    step         = 1'b0;
    item_pop_o   = 1'b0;
    res_push_o   = 1'b0;
    res_data_o   = r0;
    pend_valid_d = pend_valid_q;
    if (pend_valid_q) begin
      res_data_o = pend_q;
      res_push_o = !res_full_i;
      if (!res_full_i) begin
        pend_valid_d = 1'b0;
      end
    end else begin
      step       = item_valid_i && !res_full_i;
      item_pop_o = step;
      res_push_o = step && (n_res != 2'd0);
      if (step && n_res == 2'd2) begin
        pend_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q        <= '0;
      first_q      <= 1'b0;
      acc_q        <= '0;
      held_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      if (step) begin
        rem_q   <= rem_d;
        first_q <= first_d;
        acc_q   <= acc_d;
        held_q  <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && n_res == 2'd2) begin
      pend_q <= r1;
    end
  end

  `UMD_ASSERT(a_rem_range, rem_q <= 3'd5)
  `UMD_ASSERT(a_first_multi, first_q |-> rem_q >= 3'd2)
  `UMD_ASSERT(a_held_high, held_q != '0 |-> held_q >= HIGH_SURR_FIRST && held_q <= HIGH_SURR_LAST)
  `UMD_ASSERT(a_pend_last, pend_valid_q |-> pend_q.last && !item_pop_o)

endmodule

// ----- rtl/core/utf8_multibyte_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_multibyte_decoder
// Byte-stream decoder for 2 to 6 byte utf-8 forms with cesu-8 pairing.
// ----------------------------------------------------------------------------
// Input channel: drive item_i and push_i; a beat is taken on a clock edge with
//   push_i high and full_o low. action 0 decodes in_byte, action 1 flushes.
// Result channel: while empty_o is low the oldest result sits on result_o;
//   it is taken on an edge with pop_i high. Each input beat gives zero, one
//   or two results, the final one marked with last.
// Configuration: cfg_we_i writes cfg_data_i into the register chosen by
//   cfg_idx_i (cesu, loose, nul, overlong, super); write only while idle.
// A taken byte is registered in the input queue, then decoded and its
//   results registered in the result queue, which drives result_o.
// Throughput: one byte per cycle unless the result queue is full; the result
//   queue takes one beat a cycle, so a byte with two results holds decoding.
// The input and result queues are QueueDepth beats deep each; when the
//   receiver stalls the result queue fills, then the input queue, then full_o
//   rises. Reset empties both queues, clears the sequence state and the held
//   surrogate, and sets every configuration register to zero.
// ----------------------------------------------------------------------------
module utf8_multibyte_decoder #(
  parameter int unsigned QueueDepth = utf8md_pkg::QueueDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [utf8md_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [utf8md_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                                push_i,
  input  utf8md_pkg::in_item_t                item_i,
  output logic                                full_o,
  input  logic                                pop_i,
  output utf8md_pkg::out_item_t               result_o,
  output logic                                empty_o
);
  import utf8md_pkg::*;

  cfg_t      cfg_q;
  logic      fq_push, fq_empty, fq_pop;
  cls_item_t fq_wdata, fq_rdata;
  logic      rq_push, rq_full;
  out_item_t rq_wdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CESU_MODE:      cfg_q.cesu_mode      <= cfg_data_i[0];
        CFG_LOOSE_MODE:     cfg_q.loose_mode     <= cfg_data_i[0];
        CFG_ALLOW_NUL:      cfg_q.allow_nul      <= cfg_data_i[0];
        CFG_ALLOW_OVERLONG: cfg_q.allow_overlong <= cfg_data_i[0];
        CFG_ALLOW_SUPER:    cfg_q.allow_super    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // byte classification
  utf8md_front u_front (
    .push_i   (push_i),
    .item_i   (item_i),
    .q_push_o (fq_push),
    .q_data_o (fq_wdata)
  );

  // classified beats waiting for the decoder
  utf8md_fifo #(
    .item_t (cls_item_t),
    .Depth  (QueueDepth)
  ) u_in_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_wdata),
    .full_o  (full_o),
    .pop_i   (fq_pop),
    .data_o  (fq_rdata),
    .empty_o (fq_empty)
  );

  // sequence decoding and surrogate handling
  utf8md_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (!fq_empty),
    .item_i       (fq_rdata),
    .item_pop_o   (fq_pop),
    .res_full_i   (rq_full),
    .res_push_o   (rq_push),
    .res_data_o   (rq_wdata)
  );

  // results waiting for the receiver
  utf8md_fifo #(
    .item_t (out_item_t),
    .Depth  (QueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_wdata),
    .full_o  (rq_full),
    .pop_i   (pop_i),
    .data_o  (result_o),
    .empty_o (empty_o)
  );

endmodule

// ----- verif/tb_utf8_multibyte_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_multibyte_decoder
// Self-checking bench for the utf-8 / cesu-8 byte stream decoder. Bytes and
// flushes go in through the push queue while a behavioural decoder in the
// bench works out the results each beat must give; every popped result is
// compared field by field with the oldest of those. Directed bytes cover the
// edge cases, then random well-formed text, surrogate pairs, broken sequences
// and noise run under several mode settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_utf8_multibyte_decoder;
  import utf8md_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYC  = 12;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                push_i;
  in_item_t            item_i;
  logic                full_o;
  logic                pop_i;
  out_item_t           result_o;
  logic                empty_o;

  // decoder state as the bench sees it
  logic [3:0]  seq_ph;
  logic [30:0] acc_val;
  logic [15:0] held_hi;
  cfg_t        mode_now;

  out_item_t step_res[$];
  out_item_t results_due[$];

  int fail_count   = 0;
  int items_sent   = 0;
  int idle_cycles  = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold      = 0;

  utf8_multibyte_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push_i),
    .item_i     (item_i),
    .full_o     (full_o),
    .pop_i      (pop_i),
    .result_o   (result_o),
    .empty_o    (empty_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // behavioural decoder
  // ---------------------------------------------------------------------------

  task automatic emit_result(input kind_e k, input logic [30:0] cp);
    out_item_t r;
    r.kind       = k;
    r.code_point = (k == KIND_EMIT) ? cp : '0;
    r.last       = 1'b0;
    step_res.push_back(r);
  endtask

  // any reject drops the sequence and the held surrogate
  task automatic reject_seq();
    seq_ph  = '0;
    acc_val = '0;
    held_hi = '0;
    emit_result(KIND_REJECT, '0);
  endtask

  task automatic commit_value(input logic [30:0] u);
    logic [30:0] cp;
    seq_ph  = '0;
    acc_val = '0;
    if (u >= HIGH_SURR_FIRST && u <= HIGH_SURR_LAST) begin
      if (mode_now.cesu_mode) begin
        // a second high surrogate pushes out the first one in loose mode
        if (held_hi != 0 && !mode_now.loose_mode) begin
          reject_seq();
        end else begin
          if (held_hi != 0) emit_result(KIND_EMIT, 31'(held_hi));
          held_hi = u[15:0];
          emit_result(KIND_HELD, '0);
        end
      end else if (mode_now.loose_mode) begin
        emit_result(KIND_EMIT, u);
      end else begin
        reject_seq();
      end
    end else if (u >= LOW_SURR_FIRST && u <= LOW_SURR_LAST) begin
      if (mode_now.cesu_mode && held_hi != 0) begin
        // join the pair into one supplementary code point
        cp = SUPP_BASE;
        cp = cp | ((31'(held_hi - HIGH_SURR_FIRST) << 10) & 31'h000F_FC00);
        cp = cp | (31'(u - LOW_SURR_FIRST) & 31'h0000_03FF);
        held_hi = '0;
        emit_result(KIND_EMIT, cp);
      end else if (mode_now.loose_mode) begin
        emit_result(KIND_EMIT, u);
      end else begin
        reject_seq();
      end
    end else begin
      if (held_hi != 0 && !mode_now.loose_mode) begin
        reject_seq();
      end else begin
        if (held_hi != 0) begin
          emit_result(KIND_EMIT, 31'(held_hi));
          held_hi = '0;
        end
        if (u == 0 && !mode_now.allow_nul) reject_seq();
        else emit_result(KIND_EMIT, u);
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] d);
    logic [2:0] rem;
    rem = seq_ph[2:0];
    if (rem == 0) begin
      // lead byte: pick the form length from the prefix
      if (!d[7]) begin
        reject_seq();
      end else if (d[7:5] == 3'b110 && !mode_now.allow_overlong && d[4:1] == 4'b0000) begin
        reject_seq();
      end else if (d[7:5] == 3'b110) begin
        acc_val = 31'(d[4:0]);
        seq_ph  = 4'b0001;
        emit_result(KIND_NEED, '0);
      end else if (d[7:4] == 4'b1110) begin
        acc_val = 31'(d[3:0]);
        seq_ph  = 4'b1010;
        emit_result(KIND_NEED, '0);
      end else if (d[7:3] == 5'b11110) begin
        acc_val = 31'(d[2:0]);
        seq_ph  = 4'b1011;
        emit_result(KIND_NEED, '0);
      end else if (d[7:2] == 6'b111110 && mode_now.allow_super) begin
        acc_val = 31'(d[1:0]);
        seq_ph  = 4'b1100;
        emit_result(KIND_NEED, '0);
      end else if (d[7:1] == 7'b1111110 && mode_now.allow_super) begin
        acc_val = 31'(d[0]);
        seq_ph  = 4'b1101;
        emit_result(KIND_NEED, '0);
      end else begin
        reject_seq();
      end
    end else if (d[7:6] != 2'b10 || rem > 5) begin
      reject_seq();
    end else begin
      acc_val = {acc_val[24:0], d[5:0]};
      // overlong is known once the first continuation is in
      if (seq_ph[3] && rem >= 2 && !mode_now.allow_overlong && (acc_val >> (7 - rem)) == 0)
      begin
        reject_seq();
      end else begin
        rem = rem - 3'd1;
        if (rem == 0) begin
          commit_value(acc_val);
        end else begin
          seq_ph = {1'b0, rem};
          emit_result(KIND_NEED, '0);
        end
      end
    end
  endtask

  task automatic predict_item(input in_item_t it);
    out_item_t r;
    step_res.delete();
    if (it.action == ACT_FLUSH) begin
      if (held_hi != 0 && mode_now.loose_mode) begin
        emit_result(KIND_EMIT, 31'(held_hi));
        held_hi = '0;
      end
    end else begin
      decode_byte(it.in_byte);
    end
    foreach (step_res[i]) begin
      r      = step_res[i];
      r.last = (i == step_res.size() - 1);
      results_due.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, long hold-off, check of each beat
  // ---------------------------------------------------------------------------

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result kind %0d cp %h last %b", $time, got.kind,
               got.code_point, got.last);
    end else begin
      want = results_due.pop_front();
      if (got.kind !== want.kind || got.code_point !== want.code_point ||
          got.last !== want.last) begin
        fail_count++;
        $display("%0t: mismatch, expected kind %0d cp %h last %b, got kind %0d cp %h last %b",
                 $time, want.kind, want.code_point, want.last, got.kind, got.code_point,
                 got.last);
      end
    end
  endtask

  initial begin
    pop_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop_i && !empty_o) check_result(result_o);
      if (rx_hold > 0) begin
        rx_hold--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog on cycles without any beat on either side
  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  task automatic send_beat(input logic act, input logic [7:0] b);
    in_item_t it;
    it.action  = act;
    it.in_byte = b;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    predict_item(it);
    items_sent++;
  endtask

  // encode v as an n-byte form and send the first nbytes of it
  task automatic send_utf8(input int n, input logic [30:0] v, input int nbytes);
    logic [7:0] lead;
    int         i;
    lead = 8'hFF << (8 - n);
    lead = lead | 8'(v >> (6 * (n - 1)));
    send_beat(ACT_DECODE, lead);
    for (i = n - 2; i >= 0 && (n - 1 - i) < nbytes; i--)
      send_beat(ACT_DECODE, 8'h80 | 8'((v >> (6 * i)) & 31'h3F));
  endtask

  task automatic send_random_text();
    int          sel;
    int          n;
    int          b;
    logic [30:0] v;
    sel = $urandom_range(99);
    if (sel < 55) begin
      // any form length, magnitude spread so overlong and zero turn up
      n = $urandom_range(2, 6);
      b = $urandom_range(1, 5 * n + 1);
      v = 31'($urandom) & ((31'h1 << b) - 31'h1);
      send_utf8(n, v, n);
    end else if (sel < 65) begin
      // lone surrogate, sometimes in a longer form
      n = $urandom_range(1) ? 3 : $urandom_range(3, 6);
      v = 31'(HIGH_SURR_FIRST) + 31'($urandom_range(11'h7FF));
      send_utf8(n, v, n);
    end else if (sel < 80) begin
      send_utf8(3, 31'(HIGH_SURR_FIRST) + 31'($urandom_range(10'h3FF)), 3);
      send_utf8(3, 31'(LOW_SURR_FIRST) + 31'($urandom_range(10'h3FF)), 3);
    end else if (sel < 90) begin
      send_beat(ACT_DECODE, 8'($urandom_range(255)));
    end else if (sel < 95) begin
      // cut short, then whatever byte
      n = $urandom_range(2, 6);
      v = 31'($urandom) & ((31'h1 << (5 * n + 1)) - 31'h1);
      send_utf8(n, v, $urandom_range(1, n - 1));
      send_beat(ACT_DECODE, 8'($urandom_range(255)));
    end else begin
      send_beat(ACT_FLUSH, 8'($urandom_range(255)));
    end
  endtask

  // stop sending until every result is in, then let late beats settle
  task automatic wait_drained();
    push_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_CESU_MODE:      mode_now.cesu_mode      = val;
      CFG_LOOSE_MODE:     mode_now.loose_mode     = val;
      CFG_ALLOW_NUL:      mode_now.allow_nul      = val;
      CFG_ALLOW_OVERLONG: mode_now.allow_overlong = val;
      CFG_ALLOW_SUPER:    mode_now.allow_super    = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_modes(input cfg_t c);
    write_reg(CFG_CESU_MODE, c.cesu_mode);
    write_reg(CFG_LOOSE_MODE, c.loose_mode);
    write_reg(CFG_ALLOW_NUL, c.allow_nul);
    write_reg(CFG_ALLOW_OVERLONG, c.allow_overlong);
    write_reg(CFG_ALLOW_SUPER, c.allow_super);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // strict defaults straight out of reset
  task automatic test_reset_defaults();
    send_beat(ACT_DECODE, 8'h00);   // ascii lead
    send_beat(ACT_DECODE, 8'hFF);   // bad lead
    send_beat(ACT_DECODE, 8'hF8);   // five byte lead, super off
    send_beat(ACT_DECODE, 8'hC0);   // overlong two byte lead
    send_utf8(2, 31'h0000_07FF, 2);
    send_beat(ACT_DECODE, 8'hE2);   // three byte lead, cut by the next byte
    send_beat(ACT_DECODE, 8'h41);
    send_utf8(3, 31'(HIGH_SURR_FIRST), 3);
    wait_drained();
  endtask

  // every mode on: nul, largest six byte value, surrogate holding and flush
  task automatic test_all_modes();
    set_modes(5'b11111);
    send_beat(ACT_DECODE, 8'hC0);
    send_beat(ACT_DECODE, 8'h80);
    send_utf8(6, 31'h7FFF_FFFF, 6);
    send_utf8(3, 31'(HIGH_SURR_FIRST), 3);
    send_utf8(3, 31'(HIGH_SURR_LAST), 3);
    send_beat(ACT_FLUSH, 8'h00);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, so full_o rises
  task automatic test_backpressure();
    int stop_at;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold      = 150;
    stop_at      = items_sent + 40;
    while (items_sent < stop_at) send_random_text();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int tx_pct[4] = '{0, 86, 0, 36};
    int rx_pct[4] = '{0, 0, 86, 36};
    int stop_at;
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      for (int k = 0; k < 4; k++) begin
        if (k == 0 && p == 0) set_modes(5'b11111);
        else if (k == 0 && p == 1) set_modes(5'b00000);
        else set_modes(cfg_t'($urandom_range(31)));
        stop_at = items_sent + 75;
        while (items_sent < stop_at) begin
          send_random_text();
          if ($urandom_range(49) == 0) wait_drained();
        end
        wait_drained();
      end
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_CESU_MODE;
    cfg_data_i <= '0;
    push_i     <= 1'b0;
    item_i     <= '0;
    seq_ph   = '0;
    acc_val  = '0;
    held_hi  = '0;
    mode_now = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_all_modes();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/utf8md_pkg.sv
rtl/core/utf8md_fifo.sv
rtl/core/utf8md_front.sv
rtl/core/utf8md_back.sv
rtl/core/utf8_multibyte_decoder.sv
verif/tb_utf8_multibyte_decoder.sv
